### hdl/lav_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_pkg
// Widths, pipeline depths and rounding helpers shared by the look-at view
// matrix block and its normalizer.
// ----------------------------------------------------------------------------
package lav_pkg;

  // field widths
  localparam int IN_W   = 32;   // Q16.16 input fields
  localparam int U_W    = 18;   // unit vector components, Q2.16 in [-1, 1]
  localparam int D_W    = IN_W + 1;          // target - eye
  localparam int P_W    = U_W + IN_W;        // unit component times input field
  localparam int C_W    = P_W + 1;           // f x up
  localparam int DOT_W  = P_W + 2;           // three-term dot product
  localparam int UP_W   = 2 * U_W;           // unit times unit
  localparam int UC_W   = UP_W - 1;          // s x f, exact
  localparam int FRAC   = 16;
  localparam int ONE_Q16  = 1 << FRAC;
  localparam int RND_HALF = 1 << (FRAC - 1);

  // normalizer
  localparam int NRM_W   = 64;               // magnitude work width
  localparam int MAG_W   = 30;               // magnitude after range scaling
  localparam int LEN_W   = MAG_W + 2;        // square root result
  localparam int SQ_STEPS = NRM_W / 2;
  localparam int SQ_PER  = 2;
  localparam int SQ_STG  = SQ_STEPS / SQ_PER;
  localparam int DV_BITS = FRAC + 1;         // quotient bits, up to 1.0
  localparam int DV_PER  = 2;
  localparam int DV_STG  = (DV_BITS + DV_PER - 1) / DV_PER;
  localparam int DNW     = MAG_W + FRAC + 2; // dividend width
  // abs, max, three shift stages, squares, sum, root, divide, sign
  localparam int UNIT_LAT = 7 + SQ_STG + DV_STG + 1;

  // round a scale 2^32 product sum to Q16.16, saturate to 32 bits
  function automatic logic [IN_W-1:0] rnd_sat(input logic signed [DOT_W-1:0] x);
    logic signed [DOT_W-1:0] r;
    r = (x + DOT_W'(RND_HALF)) >>> FRAC;
    if ((&r[DOT_W-1:IN_W-1]) || !(|r[DOT_W-1:IN_W-1])) rnd_sat = r[IN_W-1:0];
    else if (r[DOT_W-1]) rnd_sat = {1'b1, {(IN_W-1){1'b0}}};
    else rnd_sat = {1'b0, {(IN_W-1){1'b1}}};
  endfunction

  // round a scale 2^32 value to Q16.16, clamp to [-1, 1]
  function automatic logic signed [U_W-1:0] rnd_clamp(input logic signed [UC_W-1:0] x);
    logic signed [UC_W-1:0] r;
    r = (x + UC_W'(RND_HALF)) >>> FRAC;
    if (r > UC_W'(ONE_Q16)) rnd_clamp = U_W'(ONE_Q16);
    else if (r < -UC_W'(ONE_Q16)) rnd_clamp = -U_W'(ONE_Q16);
    else rnd_clamp = r[U_W-1:0];
  endfunction

endpackage

### hdl/lav_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_in_if
// Camera setup channel: eye, target and up, signed Q16.16.
// ----------------------------------------------------------------------------
interface lav_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  logic signed [31:0] up_x;
  logic signed [31:0] up_y;
  logic signed [31:0] up_z;

  modport source (
    output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
    input  ready
  );
  modport sink (
    input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
    output ready
  );
endinterface

### hdl/lav_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_out_if
// View matrix channel: top three rows, vectors Q2.16 in 18 bits, w in 32 bits.
// ----------------------------------------------------------------------------
interface lav_out_if;
  logic valid;
  logic ready;
  logic signed [17:0] row0_x;
  logic signed [17:0] row0_y;
  logic signed [17:0] row0_z;
  logic signed [31:0] row0_w;
  logic signed [17:0] row1_x;
  logic signed [17:0] row1_y;
  logic signed [17:0] row1_z;
  logic signed [31:0] row1_w;
  logic signed [17:0] row2_x;
  logic signed [17:0] row2_y;
  logic signed [17:0] row2_z;
  logic signed [31:0] row2_w;

  modport source (
    output valid, row0_x, row0_y, row0_z, row0_w, row1_x, row1_y, row1_z, row1_w,
           row2_x, row2_y, row2_z, row2_w,
    input  ready
  );
  modport sink (
    input  valid, row0_x, row0_y, row0_z, row0_w, row1_x, row1_y, row1_z, row1_w,
           row2_x, row2_y, row2_z, row2_w,
    output ready
  );
endinterface

### hdl/lav_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_unit
// Pipelined 3-vector normalizer: magnitudes, range scaling, sum of squares,
// square root two bits a stage, three rounded divides two bits a stage.
// Side data rides along with the valid bit.
// ----------------------------------------------------------------------------
module lav_unit #(
  parameter int VW = lav_pkg::D_W,
  parameter int SW = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [VW-1:0]          v [3],
  input  logic [SW-1:0]                 in_side,
  output logic                          out_valid,
  output logic signed [lav_pkg::U_W-1:0] o [3],
  output logic [SW-1:0]                 out_side
);
  localparam int NW   = lav_pkg::NRM_W;
  localparam int MW   = lav_pkg::MAG_W;
  localparam int LW   = lav_pkg::LEN_W;
  localparam int DW   = lav_pkg::DNW;
  localparam int QB   = lav_pkg::DV_BITS;
  localparam int LAT  = lav_pkg::UNIT_LAT;
  localparam int SQS  = lav_pkg::SQ_STG;
  localparam int SQP  = lav_pkg::SQ_PER;
  localparam int DVS  = lav_pkg::DV_STG;
  localparam int DVP  = lav_pkg::DV_PER;

  typedef struct packed {
    logic [2:0][MW-1:0] m;
    logic [2:0]         neg;
    logic               zero;
  } mag_t;

  // valid and side data delay line
  logic [LAT-1:0] vld;
  logic [SW-1:0]  sd [LAT];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= in_side;
      for (int i = 1; i < LAT; i++) sd[i] <= sd[i-1];
    end
  end

  assign out_valid = vld[LAT-1];
  assign out_side  = sd[LAT-1];

  // magnitudes and signs
  logic [NW-1:0] a_m [3];
  logic [2:0]    a_neg;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_m[i]   <= v[i][VW-1] ? -NW'(v[i]) : NW'(v[i]);
        a_neg[i] <= v[i][VW-1];
      end
    end
  end

  // largest magnitude, zero vector flag
  logic [NW-1:0] b_max;
  logic [NW-1:0] n_big [4];
  logic [NW-1:0] n_m [4][3];
  logic [2:0]    n_neg [4];
  logic          n_zero [4];

  always_comb begin
    b_max = a_m[0];
    if (a_m[1] > b_max) b_max = a_m[1];
    if (a_m[2] > b_max) b_max = a_m[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_big[0]  <= b_max;
      n_m[0]    <= a_m;
      n_neg[0]  <= a_neg;
      n_zero[0] <= (a_m[0] | a_m[1] | a_m[2]) == '0;
    end
  end

  // left-justify the largest magnitude, two shift steps a stage
  for (genvar g = 0; g < 3; g++) begin : g_nrm
    localparam int SH0 = (NW / 2) >> (2 * g);
    localparam int SH1 = SH0 / 2;
    logic [NW-1:0] big1, big2;
    logic [NW-1:0] m1 [3];
    logic [NW-1:0] m2 [3];
    logic          c0, c1;

    always_comb begin
      c0   = (n_big[g] >> (NW - SH0)) == '0;
      big1 = c0 ? n_big[g] << SH0 : n_big[g];
      c1   = (big1 >> (NW - SH1)) == '0;
      big2 = c1 ? big1 << SH1 : big1;
      for (int i = 0; i < 3; i++) begin
        m1[i] = c0 ? n_m[g][i] << SH0 : n_m[g][i];
        m2[i] = c1 ? m1[i] << SH1 : m1[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_big[g+1]  <= big2;
        n_m[g+1]    <= m2;
        n_neg[g+1]  <= n_neg[g];
        n_zero[g+1] <= n_zero[g];
      end
    end
  end

  // top bits put the largest magnitude in [2^29, 2^30); squares
  mag_t            f_c;
  logic [2*MW-1:0] f_sq [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f_c.m[i] <= n_m[3][i][NW-1 -: MW];
        f_sq[i]  <= (2*MW)'(n_m[3][i][NW-1 -: MW]) * (2*MW)'(n_m[3][i][NW-1 -: MW]);
      end
      f_c.neg  <= n_neg[3];
      f_c.zero <= n_zero[3];
    end
  end

  // sum of squares feeds the root pipeline
  logic [NW-1:0] q_n [SQS+1];
  logic [NW-1:0] q_r [SQS+1];
  mag_t          q_c [SQS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      q_n[0] <= NW'(f_sq[0]) + NW'(f_sq[1]) + NW'(f_sq[2]);
      q_r[0] <= '0;
      q_c[0] <= f_c;
    end
  end

  // integer square root, digit-by-digit
  for (genvar k = 0; k < SQS; k++) begin : g_sqrt
    logic [NW-1:0] n_w, r_w, bit_w, t_w;

    always_comb begin
      n_w   = q_n[k];
      r_w   = q_r[k];
      bit_w = '0;
      t_w   = '0;
      for (int j = 0; j < SQP; j++) begin
        bit_w = NW'(1) << (NW - 2 - 2 * (SQP * k + j));
        t_w   = r_w + bit_w;
        if (n_w >= t_w) begin
          n_w = n_w - t_w;
          r_w = (r_w >> 1) + bit_w;
        end else begin
          r_w = r_w >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_n[k+1] <= n_w;
        q_r[k+1] <= r_w;
        q_c[k+1] <= q_c[k];
      end
    end
  end

  // rounded divide: (m * 2^16 + len/2) / len, restoring
  logic [DW-1:0] d_rem [DVS][3];
  logic [QB-1:0] d_q [DVS][3];
  logic [LW-1:0] d_len [DVS];
  logic [2:0]    d_neg [DVS];
  logic          d_zero [DVS];

  for (genvar k = 0; k < DVS; k++) begin : g_div
    logic [DW-1:0] rem_s [3];
    logic [QB-1:0] q_s [3];
    logic [LW-1:0] len_s;
    logic [2:0]    neg_s;
    logic          zero_s;
    logic [DW-1:0] rem_w [3];
    logic [QB-1:0] q_w [3];
    logic [DW-1:0] t_w;

    if (k == 0) begin : g_src
      always_comb begin
        len_s  = q_r[SQS][LW-1:0];
        neg_s  = q_c[SQS].neg;
        zero_s = q_c[SQS].zero;
        for (int i = 0; i < 3; i++) begin
          rem_s[i] = (DW'(q_c[SQS].m[i]) << lav_pkg::FRAC) + DW'(len_s >> 1);
          q_s[i]   = '0;
        end
      end
    end else begin : g_src
      always_comb begin
        len_s  = d_len[k-1];
        neg_s  = d_neg[k-1];
        zero_s = d_zero[k-1];
        for (int i = 0; i < 3; i++) begin
          rem_s[i] = d_rem[k-1][i];
          q_s[i]   = d_q[k-1][i];
        end
      end
    end

    always_comb begin
      t_w = '0;
      for (int i = 0; i < 3; i++) begin
        rem_w[i] = rem_s[i];
        q_w[i]   = q_s[i];
        for (int j = 0; j < DVP; j++) begin
          if (DVP * k + j < QB) begin
            t_w = DW'(len_s) << (QB - 1 - (DVP * k + j));
            if (rem_w[i] >= t_w) begin
              rem_w[i] = rem_w[i] - t_w;
              q_w[i][QB - 1 - (DVP * k + j)] = 1'b1;
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_rem[k]  <= rem_w;
        d_q[k]    <= q_w;
        d_len[k]  <= len_s;
        d_neg[k]  <= neg_s;
        d_zero[k] <= zero_s;
      end
    end
  end

  // apply signs; a zero vector stays zero
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (d_zero[DVS-1]) o[i] <= '0;
        else if (d_neg[DVS-1][i]) o[i] <= -lav_pkg::U_W'(d_q[DVS-1][i]);
        else o[i] <= lav_pkg::U_W'(d_q[DVS-1][i]);
      end
    end
  end

endmodule

### hdl/look_at_view_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Fixed-point look-at camera: top three rows of the view matrix from eye,
// target and up.
// ----------------------------------------------------------------------------
// One camera setup word is taken every clock and one matrix word leaves every
// clock; the stages are one for target - eye, two normalizer pipelines of 33
// stages each (their square root and divide, two result bits a stage, set the
// depth), two for f x up and four for s x f, the dot products and the output
// register. The whole pipeline holds while a finished word waits at the output
// and is not taken. A zero-length forward vector gives zero rows, a zero-length
// side vector zero rows 0 and 1; translation terms saturate to 32 bits.
// ----------------------------------------------------------------------------
module look_at_view_matrix (
  input logic       clk,
  input logic       rst,
  lav_in_if.sink    cam,
  lav_out_if.source view
);
  localparam int IW = lav_pkg::IN_W;
  localparam int UW = lav_pkg::U_W;

  typedef struct packed {
    logic [2:0][IW-1:0] eye;
    logic [2:0][IW-1:0] up;
  } side1_t;

  typedef struct packed {
    logic [2:0][IW-1:0] eye;
    logic [2:0][UW-1:0] f;
  } side2_t;

  logic en;
  logic o_v;

  // pipeline advances unless the output word is stuck
  assign en        = !o_v || view.ready;
  assign cam.ready = en;
  assign view.valid = o_v;

  // forward direction, exact
  logic                      t0_v;
  logic signed [lav_pkg::D_W-1:0] t0_d [3];
  side1_t                    t0_s;

  always_ff @(posedge clk) begin
    if (rst) t0_v <= 1'b0;
    else if (en) t0_v <= cam.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_d[0] <= lav_pkg::D_W'(cam.target_x) - lav_pkg::D_W'(cam.eye_x);
      t0_d[1] <= lav_pkg::D_W'(cam.target_y) - lav_pkg::D_W'(cam.eye_y);
      t0_d[2] <= lav_pkg::D_W'(cam.target_z) - lav_pkg::D_W'(cam.eye_z);
      t0_s.eye <= {cam.eye_z, cam.eye_y, cam.eye_x};
      t0_s.up  <= {cam.up_z, cam.up_y, cam.up_x};
    end
  end

  // f = unit(target - eye)
  logic                 u1_v;
  logic signed [UW-1:0] f_u [3];
  side1_t               u1_s;

  lav_unit #(
    .VW (lav_pkg::D_W),
    .SW ($bits(side1_t))
  ) u_fwd (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t0_v),
    .v         (t0_d),
    .in_side   (t0_s),
    .out_valid (u1_v),
    .o         (f_u),
    .out_side  (u1_s)
  );

  // f x up: products, then differences
  logic                            t1_v;
  logic signed [lav_pkg::P_W-1:0]  t1_p [6];
  side2_t                          t1_s;
  logic                            t2_v;
  logic signed [lav_pkg::C_W-1:0]  t2_c [3];
  side2_t                          t2_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
      t2_v <= 1'b0;
    end else if (en) begin
      t1_v <= u1_v;
      t2_v <= t1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_p[0] <= f_u[1] * $signed(u1_s.up[2]);
      t1_p[1] <= f_u[2] * $signed(u1_s.up[1]);
      t1_p[2] <= f_u[2] * $signed(u1_s.up[0]);
      t1_p[3] <= f_u[0] * $signed(u1_s.up[2]);
      t1_p[4] <= f_u[0] * $signed(u1_s.up[1]);
      t1_p[5] <= f_u[1] * $signed(u1_s.up[0]);
      t1_s.eye <= u1_s.eye;
      t1_s.f   <= {f_u[2], f_u[1], f_u[0]};
      t2_c[0] <= lav_pkg::C_W'(t1_p[0]) - lav_pkg::C_W'(t1_p[1]);
      t2_c[1] <= lav_pkg::C_W'(t1_p[2]) - lav_pkg::C_W'(t1_p[3]);
      t2_c[2] <= lav_pkg::C_W'(t1_p[4]) - lav_pkg::C_W'(t1_p[5]);
      t2_s    <= t1_s;
    end
  end

  // s = unit(f x up)
  logic                 u2_v;
  logic signed [UW-1:0] s_u [3];
  side2_t               u2_s;

  lav_unit #(
    .VW (lav_pkg::C_W),
    .SW ($bits(side2_t))
  ) u_side (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t2_v),
    .v         (t2_c),
    .in_side   (t2_s),
    .out_valid (u2_v),
    .o         (s_u),
    .out_side  (u2_s)
  );

  // s x f and the s, f dot products
  logic                             t3_v;
  logic signed [lav_pkg::UP_W-1:0]  t3_sf [6];
  logic signed [lav_pkg::P_W-1:0]   t3_se [3];
  logic signed [lav_pkg::P_W-1:0]   t3_fe [3];
  logic signed [UW-1:0]             t3_s [3];
  logic signed [UW-1:0]             t3_f [3];
  logic signed [IW-1:0]             t3_eye [3];

  // true up, row0 and row2 translations
  logic                 t4_v;
  logic signed [UW-1:0] t4_u [3];
  logic signed [UW-1:0] t4_s [3];
  logic signed [UW-1:0] t4_nf [3];
  logic signed [IW-1:0] t4_eye [3];
  logic [IW-1:0]        t4_w0, t4_w2;

  // u . eye products
  logic                            t5_v;
  logic signed [lav_pkg::P_W-1:0]  t5_ue [3];
  logic signed [UW-1:0]            t5_u [3];
  logic signed [UW-1:0]            t5_s [3];
  logic signed [UW-1:0]            t5_nf [3];
  logic [IW-1:0]                   t5_w0, t5_w2;

  always_ff @(posedge clk) begin
    if (rst) begin
      t3_v <= 1'b0;
      t4_v <= 1'b0;
      t5_v <= 1'b0;
      o_v  <= 1'b0;
    end else if (en) begin
      t3_v <= u2_v;
      t4_v <= t3_v;
      t5_v <= t4_v;
      o_v  <= t5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3_sf[0] <= s_u[1] * $signed(u2_s.f[2]);
      t3_sf[1] <= s_u[2] * $signed(u2_s.f[1]);
      t3_sf[2] <= s_u[2] * $signed(u2_s.f[0]);
      t3_sf[3] <= s_u[0] * $signed(u2_s.f[2]);
      t3_sf[4] <= s_u[0] * $signed(u2_s.f[1]);
      t3_sf[5] <= s_u[1] * $signed(u2_s.f[0]);
      for (int i = 0; i < 3; i++) begin
        t3_se[i]  <= s_u[i] * $signed(u2_s.eye[i]);
        t3_fe[i]  <= $signed(u2_s.f[i]) * $signed(u2_s.eye[i]);
        t3_s[i]   <= s_u[i];
        t3_f[i]   <= $signed(u2_s.f[i]);
        t3_eye[i] <= $signed(u2_s.eye[i]);
      end

      t4_u[0] <= lav_pkg::rnd_clamp(lav_pkg::UC_W'(t3_sf[0]) - lav_pkg::UC_W'(t3_sf[1]));
      t4_u[1] <= lav_pkg::rnd_clamp(lav_pkg::UC_W'(t3_sf[2]) - lav_pkg::UC_W'(t3_sf[3]));
      t4_u[2] <= lav_pkg::rnd_clamp(lav_pkg::UC_W'(t3_sf[4]) - lav_pkg::UC_W'(t3_sf[5]));
      t4_w0 <= lav_pkg::rnd_sat(-(lav_pkg::DOT_W'(t3_se[0]) + lav_pkg::DOT_W'(t3_se[1])
                                  + lav_pkg::DOT_W'(t3_se[2])));
      t4_w2 <= lav_pkg::rnd_sat(lav_pkg::DOT_W'(t3_fe[0]) + lav_pkg::DOT_W'(t3_fe[1])
                                + lav_pkg::DOT_W'(t3_fe[2]));
      for (int i = 0; i < 3; i++) begin
        t4_s[i]   <= t3_s[i];
        t4_nf[i]  <= -t3_f[i];
        t4_eye[i] <= t3_eye[i];
      end

      for (int i = 0; i < 3; i++) begin
        t5_ue[i] <= t4_u[i] * t4_eye[i];
        t5_u[i]  <= t4_u[i];
        t5_s[i]  <= t4_s[i];
        t5_nf[i] <= t4_nf[i];
      end
      t5_w0 <= t4_w0;
      t5_w2 <= t4_w2;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (en) begin
      view.row0_x <= t5_s[0];
      view.row0_y <= t5_s[1];
      view.row0_z <= t5_s[2];
      view.row0_w <= t5_w0;
      view.row1_x <= t5_u[0];
      view.row1_y <= t5_u[1];
      view.row1_z <= t5_u[2];
      view.row1_w <= lav_pkg::rnd_sat(-(lav_pkg::DOT_W'(t5_ue[0]) + lav_pkg::DOT_W'(t5_ue[1])
                                        + lav_pkg::DOT_W'(t5_ue[2])));
      view.row2_x <= t5_nf[0];
      view.row2_y <= t5_nf[1];
      view.row2_z <= t5_nf[2];
      view.row2_w <= t5_w2;
    end
  end

endmodule
